### rtl/tridiagonal_implicit_time_stepper_core_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the tridiagonal time stepper checker
// ---------------------------------------------------------------------------
`ifndef TRIDIAGONAL_IMPLICIT_TIME_STEPPER_CORE_MACROS_SVH
`define TRIDIAGONAL_IMPLICIT_TIME_STEPPER_CORE_MACROS_SVH

// same-cycle implication
`define TISTC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tistc assertion failed");

// next-cycle implication
`define TISTC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tistc assertion failed");

`endif

### rtl/tistc_pkg.sv
// ---------------------------------------------------------------------------
// tistc_pkg
// Shared constants, types and helpers of the tridiagonal time stepper.
// ---------------------------------------------------------------------------
`default_nettype none
package tistc_pkg;

    localparam int POINTS   = 64;
    localparam int VAL_W    = 32;
    localparam int IDX_W    = $clog2(POINTS);
    localparam int CNT_W    = IDX_W + 1;
    localparam int STEP_W   = 10;
    localparam int ADDR_W   = 5;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(POINTS - 1);
    localparam logic signed [VAL_W-1:0] ONE_Q16 = VAL_W'(65536);
    localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    // register indexes of the configuration port
    localparam logic [2:0] REG_LOWER = 3'd0;
    localparam logic [2:0] REG_DIAG  = 3'd1;
    localparam logic [2:0] REG_UPPER = 3'd2;
    localparam logic [2:0] REG_STEPS = 3'd3;
    localparam logic [2:0] REG_LEFT  = 3'd4;
    localparam logic [2:0] REG_RIGHT = 3'd5;

    // operands of one (x*y)/d operation
    typedef struct packed {
        logic signed [VAL_W-1:0] x;
        logic signed [VAL_W-1:0] y;
        logic signed [VAL_W-1:0] d;
    } t_md_req;

    // saturating a - b
    function automatic logic signed [VAL_W-1:0] sat_sub(
        input logic signed [VAL_W-1:0] a,
        input logic signed [VAL_W-1:0] b
    );
        logic signed [VAL_W:0] s;
        s = {a[VAL_W-1], a} - {b[VAL_W-1], b};
        if (s[VAL_W] != s[VAL_W-1]) begin
            return s[VAL_W] ? VAL_MIN : VAL_MAX;
        end
        return s[VAL_W-1:0];
    endfunction

endpackage
`default_nettype wire

### rtl/tistc_in_if.sv
// ---------------------------------------------------------------------------
// tistc_in_if
// Input channel: one right-hand-side value per item.
// ---------------------------------------------------------------------------
`default_nettype none
interface tistc_in_if import tistc_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] rhs_value;

    modport source (output valid, output rhs_value, input ready);
    modport sink   (input valid, input rhs_value, output ready);
endinterface
`default_nettype wire

### rtl/tistc_out_if.sv
// ---------------------------------------------------------------------------
// tistc_out_if
// Output channel: one solution point per item, last point flagged.
// ---------------------------------------------------------------------------
`default_nettype none
interface tistc_out_if import tistc_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] solution_value;
    logic                    last_point;

    modport source (output valid, output solution_value, output last_point, input ready);
    modport sink   (input valid, input solution_value, input last_point, output ready);
endinterface
`default_nettype wire

### rtl/tistc_muldiv.sv
// ---------------------------------------------------------------------------
// tistc_muldiv
// Shared unit: (x*y)/d, exact product, truncated quotient, saturated result.
// ---------------------------------------------------------------------------
`default_nettype none
module tistc_muldiv import tistc_pkg::*; (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_start,
    input  wire t_md_req                 i_req,
    output logic                         o_done,
    output logic signed [VAL_W-1:0]      o_q
);
    typedef enum logic [2:0] {
        ST_IDLE, ST_MUL, ST_PREP, ST_CHK, ST_DIV, ST_FIN
    } t_state;

    t_state                      r_state;
    t_md_req                     r_req;
    logic signed [2*VAL_W-1:0]   r_prod;
    logic [2*VAL_W-1:0]          r_magp;
    logic [VAL_W-1:0]            r_magd;
    logic                        r_neg;
    logic [VAL_W-1:0]            r_rem;
    logic [VAL_W-1:0]            r_qsh;
    logic [$clog2(VAL_W)-1:0]    r_cnt;
    logic                        r_done;
    logic signed [VAL_W-1:0]     r_q;

    logic [2*VAL_W-1:0]          w_thr;
    logic [VAL_W:0]              w_shift;
    logic [VAL_W:0]              w_trial;
    logic signed [VAL_W-1:0]     w_sat;

    // saturation bound: |p| >= (limit+1)*|d| overflows the quotient
    assign w_thr   = {1'b0, r_magd, {(VAL_W-1){1'b0}}}
                   + (r_neg ? {{VAL_W{1'b0}}, r_magd} : '0);
    assign w_shift = {r_rem, r_qsh[VAL_W-1]};
    assign w_trial = w_shift - {1'b0, r_magd};
    assign w_sat   = r_neg ? VAL_MIN : VAL_MAX;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_done  <= 1'b0;
        end else begin
            // flag the result for one cycle on early exit or after the last bit
            r_done <= (r_state == ST_FIN) ||
                      ((r_state == ST_CHK) && ((r_magp == '0) || (r_magd == '0) ||
                                               (r_magp >= w_thr)));
            unique case (r_state)
                ST_IDLE: begin
                    if (i_start) begin
                        r_req   <= i_req;
                        r_state <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    r_prod  <= r_req.x * r_req.y;
                    r_state <= ST_PREP;
                end
                ST_PREP: begin
                    r_neg   <= r_prod[2*VAL_W-1] ^ r_req.d[VAL_W-1];
                    r_magp  <= r_prod[2*VAL_W-1] ? (2*VAL_W)'(-r_prod) : r_prod;
                    r_magd  <= r_req.d[VAL_W-1] ? VAL_W'(-r_req.d) : r_req.d;
                    r_state <= ST_CHK;
                end
                ST_CHK: begin
                    // zero product first, then zero pivot, then overflow
                    if (r_magp == '0) begin
                        r_q     <= '0;
                        r_state <= ST_IDLE;
                    end else if (r_magd == '0 || r_magp >= w_thr) begin
                        r_q     <= w_sat;
                        r_state <= ST_IDLE;
                    end else begin
                        r_rem   <= r_magp[2*VAL_W-1:VAL_W];
                        r_qsh   <= r_magp[VAL_W-1:0];
                        r_cnt   <= '0;
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    // one restoring quotient bit per cycle
                    if (!w_trial[VAL_W]) begin
                        r_rem <= w_trial[VAL_W-1:0];
                    end else begin
                        r_rem <= w_shift[VAL_W-1:0];
                    end
                    r_qsh <= {r_qsh[VAL_W-2:0], ~w_trial[VAL_W]};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == '1) begin
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    r_q     <= r_neg ? VAL_W'(-r_qsh) : r_qsh;
                    r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_q    = r_q;
endmodule
`default_nettype wire

### rtl/tridiagonal_implicit_time_stepper_core.sv
// ---------------------------------------------------------------------------
// tridiagonal_implicit_time_stepper_core
// Implicit time stepper solving a tridiagonal system by the Thomas method.
// ---------------------------------------------------------------------------
// Usage:
//   Load POINTS (64) Q16.16 items on i_in, in point order; ready is high
//   only while loading. After the last item the block runs step_count
//   implicit steps, each a forward elimination and a back substitution, then
//   emits the 64 solution points on o_out, last_point set on the final one,
//   and returns to loading.
//   All (x*y)/d operations share one unit, one at a time: a 32x32 multiply,
//   a setup and range check, then a restoring divide for 32 quotient bits.
//   A time step takes about 256 operations. With step_count = 0 the loaded
//   values come back unchanged.
//   Each output item waits in a register until taken; a stalled receiver
//   just holds the block. Reset (synchronous) returns to loading with the
//   register defaults; the value stores are not cleared.
//   Registers sit on an APB port at byte address 4*index; writes are meant
//   to happen only while the block is loading.
// ---------------------------------------------------------------------------
`default_nettype none
module tridiagonal_implicit_time_stepper_core import tistc_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    tistc_in_if.sink               i_in,
    tistc_out_if.source            o_out,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);
    typedef enum logic [3:0] {
        ST_LOAD, ST_FRD, ST_FOP1, ST_FOP2, ST_FOP3, ST_BLAST,
        ST_BRD, ST_BOP1, ST_BOP2, ST_ORD, ST_OLD, ST_OUT
    } t_state;

    // configuration registers
    logic signed [VAL_W-1:0] r_lower, r_diag, r_upper, r_left, r_right;
    logic [STEP_W-1:0]       r_step_count;

    // value stores
    logic signed [VAL_W-1:0] field_mem [POINTS];
    logic signed [VAL_W-1:0] mdiag_mem [POINTS];
    logic signed [VAL_W-1:0] mrhs_mem  [POINTS];
    logic signed [VAL_W-1:0] r_f_rd, r_md_rd, r_mr_rd;

    // sequencer
    t_state                  r_state;
    logic [CNT_W-1:0]        r_load_cnt;
    logic [STEP_W-1:0]       r_steps;
    logic [IDX_W-1:0]        r_idx;
    logic                    r_issued;
    logic signed [VAL_W-1:0] r_piv, r_mrp, r_mdn, r_rhs, r_fn;
    logic                    r_ovalid, r_olast;
    logic signed [VAL_W-1:0] r_odata;

    logic                    w_cfg_wr, w_in_acc, w_op_state, w_start, w_done;
    logic signed [VAL_W-1:0] w_q, w_mr_new;
    t_md_req                 w_req;
    logic                    w_md_we, w_f_we;
    logic [IDX_W-1:0]        w_f_addr;
    logic signed [VAL_W-1:0] w_f_wdata, w_md_wdata;

    // configuration port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lower      <= VAL_W'(-22938);
            r_diag       <= ONE_Q16;
            r_upper      <= VAL_W'(22938);
            r_step_count <= STEP_W'(100);
            r_left       <= '0;
            r_right      <= '0;
        end else if (w_cfg_wr) begin
            unique case (paddr[ADDR_W-1:2])
                REG_LOWER: r_lower      <= pwdata;
                REG_DIAG:  r_diag       <= pwdata;
                REG_UPPER: r_upper      <= pwdata;
                REG_STEPS: r_step_count <= pwdata[STEP_W-1:0];
                REG_LEFT:  r_left       <= pwdata;
                REG_RIGHT: r_right      <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[ADDR_W-1:2])
            REG_LOWER: prdata = r_lower;
            REG_DIAG:  prdata = r_diag;
            REG_UPPER: prdata = r_upper;
            REG_STEPS: prdata = {{(32-STEP_W){1'b0}}, r_step_count};
            REG_LEFT:  prdata = r_left;
            REG_RIGHT: prdata = r_right;
            default:   prdata = '0;
        endcase
    end

    // shared multiply-divide unit
    assign w_op_state = (r_state == ST_FOP1) || (r_state == ST_FOP2) ||
                        (r_state == ST_FOP3) || (r_state == ST_BLAST) ||
                        (r_state == ST_BOP1) || (r_state == ST_BOP2);
    assign w_start    = w_op_state && !r_issued;

    always_comb begin
        case (r_state)
            ST_FOP1:  w_req = (r_idx == '0) ? '{r_lower, r_left, ONE_Q16}
                                            : '{r_upper, r_lower, r_piv};
            ST_FOP2:  w_req = '{r_upper, r_right, ONE_Q16};
            ST_FOP3:  w_req = '{r_mrp, r_lower, r_piv};
            ST_BLAST: w_req = '{r_mrp, ONE_Q16, r_piv};
            ST_BOP1:  w_req = '{r_upper, r_fn, ONE_Q16};
            ST_BOP2:  w_req = '{r_rhs, ONE_Q16, r_md_rd};
            default:  w_req = '0;
        endcase
    end

    tistc_muldiv u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_req   (w_req),
        .o_done  (w_done),
        .o_q     (w_q)
    );

    // store writes
    assign w_in_acc   = i_in.valid && i_in.ready;
    assign w_mr_new   = (r_state == ST_FOP1) ? sat_sub(r_f_rd, w_q) : sat_sub(r_rhs, w_q);
    assign w_md_we    = w_done && (((r_state == ST_FOP1) && (r_idx == '0)) ||
                                   (r_state == ST_FOP3));
    assign w_md_wdata = (r_state == ST_FOP1) ? r_diag : r_mdn;
    assign w_f_we     = w_in_acc ||
                        (w_done && ((r_state == ST_BLAST) || (r_state == ST_BOP2)));
    assign w_f_addr   = (r_state == ST_LOAD) ? r_load_cnt[IDX_W-1:0] : r_idx;
    assign w_f_wdata  = (r_state == ST_LOAD) ? i_in.rhs_value : w_q;

    always_ff @(posedge i_clk) begin
        if (w_f_we) begin
            field_mem[w_f_addr] <= w_f_wdata;
        end
        r_f_rd <= field_mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (w_md_we) begin
            mdiag_mem[r_idx] <= w_md_wdata;
            mrhs_mem[r_idx]  <= w_mr_new;
        end
        r_md_rd <= mdiag_mem[r_idx];
        r_mr_rd <= mrhs_mem[r_idx];
    end

    // sequencer: load, forward sweep, back sweep, emit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_LOAD;
            r_load_cnt <= '0;
            r_steps    <= '0;
            r_idx      <= '0;
            r_issued   <= 1'b0;
            r_ovalid   <= 1'b0;
        end else begin
            if (w_start) begin
                r_issued <= 1'b1;
            end
            if (w_done) begin
                r_issued <= 1'b0;
            end
            unique case (r_state)
                ST_LOAD: begin
                    if (w_in_acc) begin
                        if (r_load_cnt[IDX_W-1:0] == LAST_IDX) begin
                            r_load_cnt <= '0;
                            r_steps    <= '0;
                            r_idx      <= '0;
                            r_state    <= (r_step_count == '0) ? ST_ORD : ST_FRD;
                        end else begin
                            r_load_cnt <= r_load_cnt + 1'b1;
                        end
                    end
                end
                ST_FRD: r_state <= ST_FOP1;
                ST_FOP1: begin
                    if (w_done) begin
                        if (r_idx == '0) begin
                            r_piv   <= r_diag;
                            r_mrp   <= w_mr_new;
                            r_idx   <= r_idx + 1'b1;
                            r_state <= ST_FRD;
                        end else begin
                            r_mdn <= sat_sub(r_diag, w_q);
                            r_rhs <= r_f_rd;
                            r_state <= (r_idx == LAST_IDX) ? ST_FOP2 : ST_FOP3;
                        end
                    end
                end
                ST_FOP2: begin
                    if (w_done) begin
                        r_rhs   <= sat_sub(r_f_rd, w_q);
                        r_state <= ST_FOP3;
                    end
                end
                ST_FOP3: begin
                    if (w_done) begin
                        r_piv <= r_mdn;
                        r_mrp <= w_mr_new;
                        if (r_idx == LAST_IDX) begin
                            r_state <= ST_BLAST;
                        end else begin
                            r_idx   <= r_idx + 1'b1;
                            r_state <= ST_FRD;
                        end
                    end
                end
                ST_BLAST: begin
                    if (w_done) begin
                        r_fn    <= w_q;
                        r_idx   <= r_idx - 1'b1;
                        r_state <= ST_BRD;
                    end
                end
                ST_BRD: r_state <= ST_BOP1;
                ST_BOP1: begin
                    if (w_done) begin
                        r_rhs   <= sat_sub(r_mr_rd, w_q);
                        r_state <= ST_BOP2;
                    end
                end
                ST_BOP2: begin
                    if (w_done) begin
                        r_fn <= w_q;
                        if (r_idx == '0) begin
                            // step finished: run another or emit
                            r_steps <= r_steps + 1'b1;
                            r_state <= (r_steps + 1'b1 == r_step_count) ? ST_ORD : ST_FRD;
                        end else begin
                            r_idx   <= r_idx - 1'b1;
                            r_state <= ST_BRD;
                        end
                    end
                end
                ST_ORD: r_state <= ST_OLD;
                ST_OLD: begin
                    r_odata  <= r_f_rd;
                    r_olast  <= (r_idx == LAST_IDX);
                    r_ovalid <= 1'b1;
                    r_state  <= ST_OUT;
                end
                ST_OUT: begin
                    if (o_out.ready) begin
                        r_ovalid <= 1'b0;
                        if (r_idx == LAST_IDX) begin
                            r_idx   <= '0;
                            r_state <= ST_LOAD;
                        end else begin
                            r_idx   <= r_idx + 1'b1;
                            r_state <= ST_ORD;
                        end
                    end
                end
                default: r_state <= ST_LOAD;
            endcase
        end
    end

    assign i_in.ready           = (r_state == ST_LOAD);
    assign o_out.valid          = r_ovalid;
    assign o_out.solution_value = r_odata;
    assign o_out.last_point     = r_olast;
endmodule
`default_nettype wire

### rtl/tistc_checker.sv
// ---------------------------------------------------------------------------
// tistc_checker
// Port-level checks of the time stepper, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none
`include "tridiagonal_implicit_time_stepper_core_macros.svh"
module tistc_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_in_valid,
    input wire logic i_in_ready,
    input wire logic i_out_valid,
    input wire logic i_out_ready,
    input wire logic i_out_last
);
    // hold an offered item until it is taken
    `TISTC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)
    // never load while results are pending
    `TISTC_ASSERT_NOW(a_no_overlap, i_clk, i_rst_n, i_out_valid, !i_in_ready)
    // after the last point, return to loading with no output pending
    `TISTC_ASSERT_NEXT(a_last_done, i_clk, i_rst_n,
        i_out_valid && i_out_ready && i_out_last, !i_out_valid && i_in_ready)
    // the input channel stays open while it waits for an item
    `TISTC_ASSERT_NEXT(a_load_open, i_clk, i_rst_n,
        i_in_ready && !i_in_valid, i_in_ready)
endmodule

bind tridiagonal_implicit_time_stepper_core tistc_checker u_tistc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_last  (o_out.last_point)
);
`default_nettype wire
